[src/priority_tick_task_scheduler_defines.svh]
// Assertion helpers for the scheduler back end.
`ifndef PRIORITY_TICK_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TICK_TASK_SCHEDULER_DEFINES_SVH

// Checked only out of reset.
`define PTTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ptts_pkg.sv]
package ptts_pkg;

  localparam int TASK_SLOTS  = 8;
  localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int ID_W        = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PRIO_START = 8'hFF;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_CREATE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CREATE,
    OP_DELETE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    slot_idx_t  slot;
    logic [7:0] priority_val;
    logic [7:0] period;
    logic [7:0] first_delay;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FLUSH
  } back_state_t;

endpackage

[src/ptts_front.sv]
module ptts_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [2:0]        slot_id,
  input  logic [7:0]        new_priority,
  input  logic [7:0]        new_period,
  input  logic [7:0]        new_first_delay,
  output logic              push_valid,
  output ptts_pkg::cmd_t    push_cmd,
  input  logic              push_ready
);
  import ptts_pkg::*;

  logic hold_valid;
  logic hold_valid_next;
  cmd_t hold_cmd;
  cmd_t cls_cmd;
  logic cls_keep;
  logic in_range;
  logic accept;

  assign in_range = ({{(32-ID_W){1'b0}}, slot_id}) < TASK_SLOTS;
  assign accept   = in_valid && !in_stall;
  assign in_stall = hold_valid && !push_ready;

  // Decode the word; bad kinds and out-of-range slots are dropped here.
  always_comb begin
    cls_cmd.slot         = slot_idx_t'(slot_id);
    cls_cmd.priority_val = new_priority;
    cls_cmd.period       = new_period;
    cls_cmd.first_delay  = new_first_delay;
    cls_cmd.op           = OP_TICK;
    cls_keep             = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        cls_cmd.op = OP_TICK;
        cls_keep   = 1'b1;
      end
      KIND_CREATE: begin
        cls_cmd.op = OP_CREATE;
        cls_keep   = in_range;
      end
      KIND_DELETE: begin
        cls_cmd.op = OP_DELETE;
        cls_keep   = in_range;
      end
      default: begin
        cls_keep = 1'b0;
      end
    endcase
  end

  assign hold_valid_next = (accept && cls_keep) || (hold_valid && !push_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cls_keep) begin
      hold_cmd <= cls_cmd;
    end
  end

  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

endmodule

[src/ptts_queue.sv]
module ptts_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  ptts_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  output logic            pop_valid,
  output ptts_pkg::cmd_t  pop_cmd,
  input  logic            pop_ready
);
  import ptts_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[src/ptts_back.sv]
`include "priority_tick_task_scheduler_defines.svh"

module ptts_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  ptts_pkg::cmd_t  cmd,
  output logic            cmd_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output ptts_pkg::id_t   dispatched_id,
  output logic            last
);
  import ptts_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [TASK_SLOTS-1:0] slot_valid;
  logic [7:0]            slot_priority  [TASK_SLOTS];
  logic [7:0]            slot_period    [TASK_SLOTS];
  logic [7:0]            slot_countdown [TASK_SLOTS];

  slot_idx_t  idx;
  logic [7:0] best;
  logic       pend_valid;
  slot_idx_t  pend_id;
  id_t        out_id;
  logic       out_last;

  logic       idx_last;
  logic       cur_valid;
  logic [7:0] cur_prio;
  logic [7:0] cur_cd;
  logic [7:0] cur_period;
  logic       cur_ready;
  logic       cur_disp;
  logic       out_free;

  logic       cmd_pop;
  logic       walk_step;
  logic       out_load;
  slot_idx_t  out_load_id;
  logic       out_load_last;

  assign idx_last   = idx == slot_idx_t'(TASK_SLOTS - 1);
  assign cur_valid  = slot_valid[idx];
  assign cur_prio   = slot_priority[idx];
  assign cur_cd     = slot_countdown[idx];
  assign cur_period = slot_period[idx];
  assign cur_ready  = cur_valid && (cur_cd == 8'd0);
  assign cur_disp   = cur_ready && (cur_prio == best);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == OP_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (walk_step && idx_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop       = 1'b0;
    walk_step     = 1'b0;
    out_load      = 1'b0;
    out_load_id   = pend_id;
    out_load_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_SCAN: begin
        walk_step = 1'b1;
      end
      ST_UPDATE: begin
        // A new dispatch pushes out the held one, which is then known not last.
        walk_step = !(cur_disp && pend_valid && !out_free);
        out_load  = cur_disp && pend_valid && out_free;
      end
      ST_FLUSH: begin
        out_load      = pend_valid && out_free;
        out_load_last = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  assign cmd_ready = cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.op == OP_TICK) begin
        idx <= '0;
      end else if (walk_step) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      if (cmd_pop && cmd.op == OP_CREATE) begin
        slot_valid[cmd.slot] <= 1'b1;
      end
      if (cmd_pop && cmd.op == OP_DELETE) begin
        slot_valid[cmd.slot] <= 1'b0;
      end
      if (state == ST_UPDATE && walk_step && cur_disp) begin
        pend_valid <= 1'b1;
      end else if (state == ST_FLUSH && out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_TICK) begin
      best <= PRIO_START;
    end else if (state == ST_SCAN && cur_ready && cur_prio < best) begin
      best <= cur_prio;
    end
    if (state == ST_UPDATE && walk_step) begin
      if (cur_cd != 8'd0) begin
        slot_countdown[idx] <= cur_cd - 8'd1;
      end else if (cur_disp) begin
        slot_countdown[idx] <= cur_period + 8'hFF;
      end
      if (cur_disp) begin
        pend_id <= idx;
      end
    end
    if (cmd_pop && cmd.op == OP_CREATE) begin
      slot_priority[cmd.slot]  <= cmd.priority_val;
      slot_period[cmd.slot]    <= cmd.period;
      slot_countdown[cmd.slot] <= cmd.first_delay;
    end
    if (out_load) begin
      out_id   <= id_t'(out_load_id);
      out_last <= out_load_last;
    end
  end

  assign dispatched_id = out_id;
  assign last          = out_last;

  `PTTS_ASSERT(a_pop_idle, cmd_pop |-> state == ST_IDLE, "command taken outside idle")
  `PTTS_ASSERT(a_pend_walk, pend_valid |-> (state == ST_UPDATE || state == ST_FLUSH), "held dispatch outside tick")
  `PTTS_ASSERT(a_flush_done, (state == ST_FLUSH && !pend_valid) |=> state == ST_IDLE, "flush did not finish")
  `PTTS_ASSERT(a_last_flush, (out_load && out_load_last) |=> (state == ST_IDLE && !pend_valid), "last word left a dispatch behind")
  `PTTS_ASSERT_ALWAYS(a_rst_quiet, rst |=> (!out_valid && state == ST_IDLE), "reset left output busy")

endmodule

[src/priority_tick_task_scheduler.sv]
// Priority tick scheduler over TASK_SLOTS task slots. The back end takes create and delete
// words while idle. A tick in the back end makes one pass over the slot table to find the
// best ready priority, a second pass that decrements each nonzero countdown, reloads the
// countdown of each dispatched slot and emits dispatches in slot order, and a flush step
// that releases the final dispatch, which carries last. The back end walks the table one
// slot per cycle, which sets the tick time; a stalled output lengthens the update pass.
// A two-word queue between the front and back ends buffers input words during a tick.
module priority_tick_task_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [2:0] slot_id,
  input  logic [7:0] new_priority,
  input  logic [7:0] new_period,
  input  logic [7:0] new_first_delay,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] dispatched_id,
  output logic       last
);
  import ptts_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  ptts_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .slot_id         (slot_id),
    .new_priority    (new_priority),
    .new_period      (new_period),
    .new_first_delay (new_first_delay),
    .push_valid      (push_valid),
    .push_cmd        (push_cmd),
    .push_ready      (push_ready)
  );

  ptts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  ptts_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (pop_valid),
    .cmd           (pop_cmd),
    .cmd_ready     (pop_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dispatched_id (dispatched_id),
    .last          (last)
  );

endmodule
